// ----- src/i2a_pkg.sv -----
// Shared constants, the conversion-to-output handoff type and the digit lookup.
package i2a_pkg;

   // Field widths of the request
   localparam int VAL_W      = 64;
   localparam int FW_W       = 6;

   // Digit buffer, one 4-bit digit per place, most significant digit at the top
   localparam int MAX_DIGITS = 22;
   localparam int BUF_W      = 4 * MAX_DIGITS;
   localparam int OCT_W      = 3 * MAX_DIGITS;
   localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int BIT_CNT_W  = $clog2(VAL_W);

   // Radix selector codes; the unused code is handled as decimal
   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_HEX = 2'd2;

   // ASCII characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_A_UP  = 8'h41;
   localparam logic [7:0] CH_A_LO  = 8'h61;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_X_LO  = 8'h78;

   // Converted number plus the layout controls, handed to the output sequencer
   typedef struct packed {
      logic [BUF_W-1:0]     digits;
      logic [DIG_CNT_W-1:0] ndig;
      logic                 upper_hex;
      logic                 has_sign;
      logic [7:0]           sign_char;
      logic [1:0]           npre;
      logic                 left;
      logic                 zero;
      logic [FW_W-1:0]      width;
   } i2a_job_type;

   // One digit to its ASCII character
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CH_ZERO + {4'b0, d};
      end else if (upper) begin
         c = CH_A_UP + {4'b0, d - 4'd10};
      end else begin
         c = CH_A_LO + {4'b0, d - 4'd10};
      end
      return c;
   endfunction

endpackage

// ----- src/i2a_if.sv -----
// Request and response channel interfaces of the integer formatter.
interface i2a_req_if;
   import i2a_pkg::*;
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] value;
   logic [1:0]       radix_sel;
   logic             signed_mode;
   logic             upper_case;
   logic             flag_left;
   logic             flag_plus;
   logic             flag_space;
   logic             flag_hash;
   logic             flag_zero;
   logic [FW_W-1:0]  field_width;

   modport source (output valid, value, radix_sel, signed_mode, upper_case, flag_left,
                   flag_plus, flag_space, flag_hash, flag_zero, field_width,
                   input ready);
   modport sink (input valid, value, radix_sel, signed_mode, upper_case, flag_left,
                 flag_plus, flag_space, flag_hash, flag_zero, field_width,
                 output ready);
endinterface

interface i2a_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source (output valid, out_char, last, input ready);
   modport sink (input valid, out_char, last, output ready);
endinterface

// ----- src/i2a_conv.sv -----
// Digit conversion: bit-serial binary to BCD for decimal, direct slicing for octal and hex.
module i2a_conv (
   input  logic                 clock,
   input  logic                 reset,
   i2a_req_if.sink              req_chan,
   output i2a_pkg::i2a_job_type job,
   output logic                 job_valid,
   input  logic                 job_ready
);
   import i2a_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_DABBLE, ST_SCAN, ST_HOLD} state_type;

   state_type             state_ff, state_in;
   i2a_job_type           job_ff, job_in;
   logic [VAL_W-1:0]      mag_ff, mag_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;

   logic [BUF_W-1:0]      adj;
   logic [BUF_W-1:0]      oct_digits;
   logic [OCT_W-1:0]      oct_src;
   logic [VAL_W-1:0]      neg_value;
   logic                  is_oct, is_hex, is_dec, is_neg, nonneg_signed;

   function automatic logic [3:0] bcd_digit(input int i);
      return job_ff.digits[4*i +: 4];
   endfunction

   // request decode
   assign is_oct        = (req_chan.radix_sel == RADIX_OCT);
   assign is_hex        = (req_chan.radix_sel == RADIX_HEX);
   assign is_dec        = !is_oct && !is_hex;
   assign is_neg        = is_dec && req_chan.signed_mode && req_chan.value[VAL_W-1];
   assign nonneg_signed = is_dec && req_chan.signed_mode && !req_chan.value[VAL_W-1];
   assign neg_value     = ~req_chan.value + VAL_W'(1);
   assign oct_src       = OCT_W'(req_chan.value);

   // add-3 correction on every BCD digit, and octal regrouping into 4-bit digits
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_digit(i) >= 4'd5) ? bcd_digit(i) + 4'd3 : bcd_digit(i);
         oct_digits[4*i +: 4] = {1'b0, oct_src[3*i +: 3]};
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      mag_in     = mag_ff;
      bit_cnt_in = bit_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               job_in.ndig      = DIG_CNT_W'(MAX_DIGITS);
               job_in.upper_hex = is_hex && req_chan.upper_case;
               job_in.has_sign  = is_neg || (nonneg_signed &&
                                  (req_chan.flag_plus || req_chan.flag_space));
               job_in.sign_char = is_neg ? CH_MINUS :
                                  (req_chan.flag_plus ? CH_PLUS : CH_SPACE);
               job_in.npre      = 2'd0;
               if (req_chan.flag_hash && (req_chan.value != '0)) begin
                  job_in.npre = is_hex ? 2'd2 : (is_oct ? 2'd1 : 2'd0);
               end
               job_in.left      = req_chan.flag_left;
               job_in.zero      = req_chan.flag_zero;
               job_in.width     = req_chan.field_width;
               mag_in           = is_neg ? neg_value : req_chan.value;
               bit_cnt_in       = BIT_CNT_W'(VAL_W - 1);
               if (is_hex) begin
                  job_in.digits = BUF_W'(req_chan.value);
                  state_in      = ST_SCAN;
               end else if (is_oct) begin
                  job_in.digits = oct_digits;
                  state_in      = ST_SCAN;
               end else begin
                  job_in.digits = '0;
                  state_in      = ST_DABBLE;
               end
            end
         end
         ST_DABBLE: begin
            // one magnitude bit per cycle into the BCD register
            job_in.digits = {adj[BUF_W-2:0], mag_ff[VAL_W-1]};
            mag_in        = {mag_ff[VAL_W-2:0], 1'b0};
            bit_cnt_in    = bit_cnt_ff - BIT_CNT_W'(1);
            if (bit_cnt_ff == '0) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // drop leading zero digits, keeping at least one
            if ((job_ff.digits[BUF_W-1 -: 4] == 4'd0) && (job_ff.ndig > DIG_CNT_W'(1))) begin
               job_in.digits = {job_ff.digits[BUF_W-5:0], 4'd0};
               job_in.ndig   = job_ff.ndig - DIG_CNT_W'(1);
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (job_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff   <= state_in;
         job_ff     <= job_in;
         mag_ff     <= mag_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign job_valid      = (state_ff == ST_HOLD);
   assign job            = job_ff;

endmodule

// ----- src/i2a_emit.sv -----
// Output sequencer: pads, sign, prefix and digits, one character per cycle while the receiver is ready.
module i2a_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  i2a_pkg::i2a_job_type job,
   input  logic                 job_valid,
   output logic                 job_ready,
   i2a_rsp_if.source            rsp_chan
);
   import i2a_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_LPAD, ST_SIGN, ST_PRE, ST_ZPAD, ST_DIGS, ST_RPAD
   } state_type;

   state_type        state_ff, state_in;
   i2a_job_type      job_ff, job_in;
   logic [FW_W-1:0]  pad_ff, pad_in;
   logic [FW_W-1:0]  cnt_ff, cnt_in;

   logic [FW_W-1:0]  len, pad_calc;
   logic             has_lpad, has_zpad, has_rpad, has_pre;
   state_type        after_prep, after_lpad, after_sign, after_pre, after_digs, after_cur;
   logic             fire;
   logic [7:0]       char_x;

   // the characters other than padding decide how much padding there is
   assign len      = FW_W'(job.ndig) + FW_W'(job.npre) + FW_W'(job.has_sign);
   assign pad_calc = (job.width > len) ? job.width - len : '0;

   assign has_lpad = !job_ff.left && !job_ff.zero && (pad_ff != '0);
   assign has_zpad = !job_ff.left && job_ff.zero && (pad_ff != '0);
   assign has_rpad = job_ff.left && (pad_ff != '0);
   assign has_pre  = (job_ff.npre != 2'd0);

   // phase order, skipping empty phases
   assign after_pre  = has_zpad ? ST_ZPAD : ST_DIGS;
   assign after_sign = has_pre ? ST_PRE : after_pre;
   assign after_lpad = job_ff.has_sign ? ST_SIGN : after_sign;
   assign after_prep = has_lpad ? ST_LPAD : after_lpad;
   assign after_digs = has_rpad ? ST_RPAD : ST_IDLE;

   always_comb begin
      unique case (state_ff)
         ST_LPAD: after_cur = after_lpad;
         ST_SIGN: after_cur = after_sign;
         ST_PRE:  after_cur = after_pre;
         ST_ZPAD: after_cur = ST_DIGS;
         ST_DIGS: after_cur = after_digs;
         default: after_cur = ST_IDLE;
      endcase
   end

   // characters a phase emits
   function automatic logic [FW_W-1:0] phase_count(input state_type ph,
                                                   input i2a_job_type j,
                                                   input logic [FW_W-1:0] pad);
      logic [FW_W-1:0] n;
      case (ph)
         ST_LPAD, ST_ZPAD, ST_RPAD: n = pad;
         ST_SIGN:                   n = FW_W'(1);
         ST_PRE:                    n = FW_W'(j.npre);
         ST_DIGS:                   n = FW_W'(j.ndig);
         default:                   n = '0;
      endcase
      return n;
   endfunction

   assign fire = rsp_chan.valid && rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      pad_in   = pad_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in   = job;
               pad_in   = pad_calc;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = after_prep;
            cnt_in   = phase_count(after_prep, job_ff, pad_ff);
         end
         default: begin
            if (fire) begin
               if (state_ff == ST_DIGS) begin
                  job_in.digits = {job_ff.digits[BUF_W-5:0], 4'd0};
               end
               if (cnt_ff > FW_W'(1)) begin
                  cnt_in = cnt_ff - FW_W'(1);
               end else begin
                  state_in = after_cur;
                  cnt_in   = phase_count(after_cur, job_ff, pad_ff);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         pad_ff   <= pad_in;
         cnt_ff   <= cnt_in;
      end
   end

   // character select
   assign char_x = job_ff.upper_hex ? CH_X_UP : CH_X_LO;

   always_comb begin
      case (state_ff)
         ST_SIGN: rsp_chan.out_char = job_ff.sign_char;
         ST_PRE:  rsp_chan.out_char = ((cnt_ff == FW_W'(1)) && (job_ff.npre == 2'd2)) ?
                                      char_x : CH_ZERO;
         ST_ZPAD: rsp_chan.out_char = CH_ZERO;
         ST_DIGS: rsp_chan.out_char = digit_char(job_ff.digits[BUF_W-1 -: 4],
                                                 job_ff.upper_hex);
         default: rsp_chan.out_char = CH_SPACE;
      endcase
   end

   assign rsp_chan.valid = (state_ff != ST_IDLE) && (state_ff != ST_PREP);
   assign rsp_chan.last  = (cnt_ff == FW_W'(1)) &&
                           (((state_ff == ST_DIGS) && !has_rpad) || (state_ff == ST_RPAD));
   assign job_ready      = (state_ff == ST_IDLE);

endmodule

// ----- src/integer_to_ascii_formatter.sv -----
// Top level of the printf-style integer to ASCII formatter.
// Each request carries a 64-bit value with radix, sign and printf flags and comes back as
// a stream of ASCII characters, one per response, with last on the final one. Conversion
// accepts the request, then for decimal runs a bit-serial binary to BCD conversion (octal
// and hex skip this), then strips leading zero digits (at most 21 digits dropped), then
// hands the job over. Output passes a setup state and then sends one character per cycle
// while the receiver is ready, between 1 and 63 characters. Conversion of the next
// request overlaps output of the current one, so the bit-serial BCD loop and the
// character output sequencer set how often requests can be taken.
module integer_to_ascii_formatter (
   input logic        clock,
   input logic        reset,
   i2a_req_if.sink    req_chan,
   i2a_rsp_if.source  rsp_chan
);
   import i2a_pkg::*;

   i2a_job_type job;
   logic        job_valid;
   logic        job_ready;

   // digit conversion
   i2a_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .job       (job),
      .job_valid (job_valid),
      .job_ready (job_ready)
   );

   // character output
   i2a_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .rsp_chan  (rsp_chan)
   );

   // the final character of a request is followed by an idle cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last |=> !rsp_chan.valid)
      else $error("response valid right after last character");

   // handed-over digit count is within the buffer
   assert property (@(posedge clock) disable iff (reset)
      job_valid |-> (job.ndig != '0) && (job.ndig <= DIG_CNT_W'(MAX_DIGITS)))
      else $error("digit count out of range at handoff");

   // converter is busy after taking a request
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("converter ready again right after a request");

   // a waiting handoff holds its contents
   assert property (@(posedge clock) disable iff (reset)
      job_valid && !job_ready |=> job_valid && $stable(job))
      else $error("handoff changed while waiting");

endmodule
